// ----- rtl/core/ppr_pkg.sv -----
// Shared types, constants and colour conversion helpers for the planar
// palette to RGB555 converter. No dependencies.
package ppr_pkg;

    localparam int PAL_ENTRIES = 16;
    localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
    localparam int COLOR_W     = 12;
    localparam int PIX_W       = 15;
    localparam int PIXELS      = 8;
    localparam int PLANES      = 4;
    localparam int NIB_W       = 4;
    localparam int CH_W        = 5;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_CONVERT = 1'b1
    } kind_t;

    typedef logic [PAL_IDX_W-1:0] pal_idx_t;
    typedef logic [COLOR_W-1:0]   color_t;
    typedef logic [PIX_W-1:0]     pixel_t;

    typedef pal_idx_t [PIXELS-1:0] idx_vec_t;
    typedef color_t   [PIXELS-1:0] color_vec_t;
    typedef pixel_t   [PIXELS-1:0] pixel_vec_t;

    // palette write request
    typedef struct packed {
        logic     en;
        pal_idx_t idx;
        color_t   color;
    } pal_wr_t;

    // n replicated to 8 bits, then top five bits kept
    function automatic logic [CH_W-1:0] widen_cut(input logic [NIB_W-1:0] nib);
        logic [2*NIB_W-1:0] v8;
        v8 = {nib, nib};
        return v8[2*NIB_W-1 -: CH_W];
    endfunction

    function automatic pixel_t to_rgb555(input color_t c);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        r = widen_cut(c[11:8]);
        g = widen_cut(c[7:4]);
        b = widen_cut(c[3:0]);
        return {b, g, r};
    endfunction

endpackage

// ----- rtl/core/ppr_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ppr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/core/ppr_palette.sv -----
// Palette store: four replicated dual-read RAMs give eight lookups a cycle.
// Per-entry valid bits make unwritten entries read as black. Uses ppr_pkg, ppr_ram.
module ppr_palette
    import ppr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pal_wr_t    wr,
    input  logic       rd_en,
    input  idx_vec_t   rd_idx,
    output color_vec_t rd_color
);

    logic [PAL_ENTRIES-1:0] entry_valid_reg;
    logic [PAL_ENTRIES-1:0] entry_valid_next;
    logic [PIXELS-1:0]      rd_ok_reg;
    color_vec_t             ram_data;

    always_comb begin
        entry_valid_next = entry_valid_reg;
        if (wr.en) begin
            entry_valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int k = 0; k < PIXELS; k++) begin
                rd_ok_reg[k] <= entry_valid_reg[rd_idx[k]];
            end
        end
    end

    for (genvar i = 0; i < PIXELS / 2; i++) begin : g_bank
        ppr_ram #(
            .WIDTH (COLOR_W),
            .DEPTH (PAL_ENTRIES)
        ) u_ram (
            .aclk    (aclk),
            .we      (wr.en),
            .waddr   (wr.idx),
            .wdata   (wr.color),
            .re      (rd_en),
            .raddr_a (rd_idx[2*i]),
            .raddr_b (rd_idx[2*i+1]),
            .rdata_a (ram_data[2*i]),
            .rdata_b (ram_data[2*i+1])
        );
    end

    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            rd_color[k] = rd_ok_reg[k] ? ram_data[k] : '0;
        end
    end

    wr_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> entry_valid_reg[$past(wr.idx)])
        else $error("palette write did not mark entry valid");

endmodule

// ----- rtl/core/ppr_out_stage.sv -----
// Output register: packs palette colours into RGB555 and holds them until
// the receiver takes the transfer. Uses ppr_pkg.
module ppr_out_stage
    import ppr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  color_vec_t in_color,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_vec_t out_pixel
);

    logic       valid_reg;
    logic       valid_next;
    pixel_vec_t pixel_reg;
    pixel_vec_t pixel_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        for (int k = 0; k < PIXELS; k++) begin
            pixel_next[k] = to_rgb555(in_color[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ----- rtl/core/planar_palette_to_rgb555_top.sv -----
// Top level of the planar palette to RGB555 converter.
// Uses ppr_pkg, ppr_palette, ppr_out_stage.
//
// Input channel (s_valid/s_ready): kind 0 writes entry_color into palette
// entry entry_index and gives no result; kind 1 takes one byte of each of
// four planes and gives one result transfer of eight 15-bit pixels
// (pixel_0 from bit 7, blue<<10 | green<<5 | red).
// Output channel (m_valid/m_ready) carries m_pixel_0 .. m_pixel_7.
// A convert item accepted on s_* is registered first in the palette RAM
// read register and then in the output register, which presents it on m_*.
// Throughput: one item per cycle while m_ready does not stall the output,
// set by the eight palette lookups done in parallel on four replicated
// dual-read RAMs. A load is visible to a convert item accepted in the very
// next cycle.
// Reset: synchronous aresetn clears the pipeline and marks every palette
// entry as black; no clearing pass, items are taken straight away.
// Stall: while m_ready is low the result holds; one more convert item
// waits in the RAM read stage, after which s_ready drops. Loads are taken
// whenever s_ready is high.
module planar_palette_to_rgb555_top
    import ppr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_kind,
    input  logic [3:0]    s_entry_index,
    input  logic [11:0]   s_entry_color,
    input  logic [7:0]    s_plane0_byte,
    input  logic [7:0]    s_plane1_byte,
    input  logic [7:0]    s_plane2_byte,
    input  logic [7:0]    s_plane3_byte,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [14:0]   m_pixel_0,
    output logic [14:0]   m_pixel_1,
    output logic [14:0]   m_pixel_2,
    output logic [14:0]   m_pixel_3,
    output logic [14:0]   m_pixel_4,
    output logic [14:0]   m_pixel_5,
    output logic [14:0]   m_pixel_6,
    output logic [14:0]   m_pixel_7
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       out_ready;
    logic       s_xfer;
    logic       cvt_xfer;
    pal_wr_t    pal_wr;
    idx_vec_t   pix_idx;
    color_vec_t s1_color;
    pixel_vec_t pixels;

    assign s_ready  = !s1_valid_reg || out_ready;
    assign s_xfer   = s_valid && s_ready;
    assign cvt_xfer = s_xfer && (kind_t'(s_kind) == KIND_CONVERT);

    assign pal_wr.en    = s_xfer && (kind_t'(s_kind) == KIND_LOAD);
    assign pal_wr.idx   = s_entry_index;
    assign pal_wr.color = s_entry_color;

    // plane p supplies bit p of each index; pixel k comes from bit 7-k
    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            pix_idx[k] = {s_plane3_byte[PIXELS-1-k], s_plane2_byte[PIXELS-1-k],
                          s_plane1_byte[PIXELS-1-k], s_plane0_byte[PIXELS-1-k]};
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_ready) begin
            s1_valid_next = cvt_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    ppr_palette u_palette (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (pal_wr),
        .rd_en    (cvt_xfer),
        .rd_idx   (pix_idx),
        .rd_color (s1_color)
    );

    ppr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_color  (s1_color),
        .in_ready  (out_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (pixels)
    );

    assign m_pixel_0 = pixels[0];
    assign m_pixel_1 = pixels[1];
    assign m_pixel_2 = pixels[2];
    assign m_pixel_3 = pixels[3];
    assign m_pixel_4 = pixels[4];
    assign m_pixel_5 = pixels[5];
    assign m_pixel_6 = pixels[6];
    assign m_pixel_7 = pixels[7];

    s1_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("read stage dropped an item while stalled");

    load_gives_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pal_wr.en |=> !s1_valid_reg)
        else $error("load transfer produced a pending result");

    convert_enters_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        cvt_xfer |=> s1_valid_reg)
        else $error("convert transfer lost before read stage");

endmodule

// ----- tb/tb_planar_palette_to_rgb555_top.sv -----
// Testbench for planar_palette_to_rgb555_top: palette loads and plane-group conversions
// checked against a palette shadow, with random idling on both channels.
// Depends on ppr_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_planar_palette_to_rgb555_top;
    import ppr_pkg::*;

    typedef struct {
        kind_t            kind;
        logic [3:0]       entry_index;
        logic [11:0]      entry_color;
        logic [3:0][7:0]  planes;
        bit               hold_off;   // wait for all pixels out before sending
    } plane_req_t;

    localparam logic [11:0] SEED_COLORS [16] = '{
        12'h000, 12'hFFF, 12'hF00, 12'h0F0, 12'h00F, 12'h888, 12'h777, 12'h123,
        12'h456, 12'h789, 12'hABC, 12'hDEF, 12'h5A5, 12'hA5A, 12'h0F8, 12'h1E7
    };

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [3:0]  s_entry_index = '0;
    logic [11:0] s_entry_color = '0;
    logic [7:0]  s_plane0_byte = '0;
    logic [7:0]  s_plane1_byte = '0;
    logic [7:0]  s_plane2_byte = '0;
    logic [7:0]  s_plane3_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [14:0] m_pixel_0, m_pixel_1, m_pixel_2, m_pixel_3;
    logic [14:0] m_pixel_4, m_pixel_5, m_pixel_6, m_pixel_7;

    plane_req_t  pending_reqs [$];
    pixel_vec_t  pixels_due [$];
    logic [11:0] palette_shadow [16];

    int driven_count   = 0;
    int taken_count    = 0;
    int mismatch_count = 0;
    int cycle_cnt      = 0;
    bit calm;

    planar_palette_to_rgb555_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_entry_index (s_entry_index),
        .s_entry_color (s_entry_color),
        .s_plane0_byte (s_plane0_byte),
        .s_plane1_byte (s_plane1_byte),
        .s_plane2_byte (s_plane2_byte),
        .s_plane3_byte (s_plane3_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_0     (m_pixel_0),
        .m_pixel_1     (m_pixel_1),
        .m_pixel_2     (m_pixel_2),
        .m_pixel_3     (m_pixel_3),
        .m_pixel_4     (m_pixel_4),
        .m_pixel_5     (m_pixel_5),
        .m_pixel_6     (m_pixel_6),
        .m_pixel_7     (m_pixel_7)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // no idling on either side inside this window
    assign calm = (cycle_cnt >= 250) && (cycle_cnt < 550);

    // nibble n widened to {n,n}, top five bits kept: {n, n[3]}
    function automatic pixel_t rgb555_of(logic [11:0] c);
        return {c[3:0], c[3], c[7:4], c[7], c[11:8], c[11]};
    endfunction

    function automatic pixel_vec_t expand_group(logic [3:0][7:0] planes);
        pixel_vec_t px;
        logic [3:0] idx;
        for (int k = 0; k < 8; k++) begin
            for (int p = 0; p < 4; p++)
                idx[p] = planes[p][7-k];
            px[k] = rgb555_of(palette_shadow[idx]);
        end
        return px;
    endfunction

    function automatic void queue_load(logic [3:0] idx, logic [11:0] color);
        plane_req_t r;
        r.kind        = KIND_LOAD;
        r.entry_index = idx;
        r.entry_color = color;
        r.planes      = $urandom;
        r.hold_off    = 1'b0;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_convert(logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3);
        plane_req_t r;
        r.kind        = KIND_CONVERT;
        r.entry_index = 4'($urandom_range(15));
        r.entry_color = 12'($urandom_range(4095));
        r.planes      = {b3, b2, b1, b0};
        r.hold_off    = 1'b0;
        pending_reqs.push_back(r);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && taken_count != driven_count) begin
            // transfer still pending: hold
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].hold_off && pixels_due.size() != 0) ||
                     (!calm && $urandom_range(99) < 14)) begin
            s_valid <= 1'b0;
        end else begin
            plane_req_t r;
            r = pending_reqs.pop_front();
            s_kind        <= r.kind;
            s_entry_index <= r.entry_index;
            s_entry_color <= r.entry_color;
            s_plane0_byte <= r.planes[0];
            s_plane1_byte <= r.planes[1];
            s_plane2_byte <= r.planes[2];
            s_plane3_byte <= r.planes[3];
            s_valid       <= 1'b1;
            driven_count++;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 14);
    end

    // monitor and prediction
    always @(posedge aclk) begin
        pixel_vec_t got;
        pixel_vec_t want;
        cycle_cnt++;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++)
                palette_shadow[i] = '0;
        end else begin
            if (s_valid && s_ready) begin
                taken_count++;
                if (s_kind == KIND_CONVERT)
                    pixels_due.push_back(expand_group(
                        {s_plane3_byte, s_plane2_byte, s_plane1_byte, s_plane0_byte}));
                else
                    palette_shadow[s_entry_index] = s_entry_color;
            end
            if (m_valid && m_ready) begin
                got = {m_pixel_7, m_pixel_6, m_pixel_5, m_pixel_4,
                       m_pixel_3, m_pixel_2, m_pixel_1, m_pixel_0};
                if (pixels_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result transfer %h", $time, got);
                end else begin
                    want = pixels_due.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (got[k] !== want[k]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("%0t: pixel_%0d expected %h got %h",
                                         $time, k, want[k], got[k]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        // palette still black from reset
        queue_convert(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 16; i++)
            queue_load(4'(i), SEED_COLORS[i]);
        queue_convert(8'h00, 8'h00, 8'h00, 8'h00);
        queue_convert(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_convert(8'hFF, 8'h00, 8'h00, 8'h00);
        queue_convert(8'h00, 8'h00, 8'h00, 8'hFF);
        queue_convert(8'hAA, 8'hCC, 8'hF0, 8'h00);
        queue_convert(8'h55, 8'h33, 8'h0F, 8'hFF);
        // overwrite an entry and use it on the next transfer
        queue_load(4'd5, 12'hC3E);
        queue_convert(8'h01, 8'h00, 8'h01, 8'h00);

        for (int n = 0; n < 550; n++) begin
            if ($urandom_range(99) < 35)
                queue_load(4'($urandom_range(15)), 12'($urandom_range(4095)));
            else
                queue_convert(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
            if (n == 0 || n == 275)
                pending_reqs[pending_reqs.size()-1].hold_off = 1'b1;
        end

        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        while (pending_reqs.size() != 0 || taken_count != driven_count)
            @(posedge aclk);
        while (pixels_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && pixels_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
